[hw/rtl/ccms_pkg.sv]
// ----------------------------------------------------------------------------
// ccms_pkg
// Shared codes, widths and controller/datapath interface types for the
// cyclic message scheduler.
// ----------------------------------------------------------------------------
package ccms_pkg;

  // entries addressable through the 4-bit index
  localparam int MAX_ENTRIES = 16;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // input modes (in_tuser)
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_TXDONE = 2'd1;
  localparam logic [1:0] MODE_RXSEEN = 2'd2;
  localparam logic [1:0] MODE_LOAD   = 2'd3;

  // result kinds (out_tuser)
  localparam logic [1:0] KIND_TXREQ  = 2'd0;
  localparam logic [1:0] KIND_RXTO   = 2'd1;
  localparam logic [1:0] KIND_TXTO   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // scan phase of a timer pass
  localparam logic [1:0] SCAN_NONE  = 2'd0;
  localparam logic [1:0] SCAN_TXREQ = 2'd1;
  localparam logic [1:0] SCAN_RXTO  = 2'd2;
  localparam logic [1:0] SCAN_TXTO  = 2'd3;

  typedef struct packed {
    logic       accept;   // latch the input beat
    logic [1:0] scan;     // active scan phase
    logic       update;   // apply a done/seen/load item
    logic       status;   // emit the closing status beat
  } ccms_cmd_t;

  typedef struct packed {
    logic slot_free;      // output register can take a beat this cycle
    logic scan_done;      // current scan phase finishes this cycle
  } ccms_sts_t;

endpackage

[hw/rtl/ccms_ctrl.sv]
// ----------------------------------------------------------------------------
// ccms_ctrl
// Sequencer: accepts one item, runs the scan phases of a timer pass or the
// single update step, then issues the status beat.
// ----------------------------------------------------------------------------
module ccms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_mode,
  input  ccms_pkg::ccms_sts_t sts,
  output ccms_pkg::ccms_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_TXREQ = 3'd2;
  localparam logic [2:0] ST_RXTO  = 3'd3;
  localparam logic [2:0] ST_TXTO  = 3'd4;
  localparam logic [2:0] ST_STAT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.accept = in_tvalid && in_tready;
  assign cmd.update = (state_r == ST_UPD);
  assign cmd.status = (state_r == ST_STAT);

  always_comb begin
    unique case (state_r)
      ST_TXREQ: cmd.scan = ccms_pkg::SCAN_TXREQ;
      ST_RXTO:  cmd.scan = ccms_pkg::SCAN_RXTO;
      ST_TXTO:  cmd.scan = ccms_pkg::SCAN_TXTO;
      default:  cmd.scan = ccms_pkg::SCAN_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = (in_mode == ccms_pkg::MODE_PASS) ? ST_TXREQ : ST_UPD;
        end
      end
      ST_UPD:   state_nxt = ST_STAT;
      ST_TXREQ: if (sts.scan_done) state_nxt = ST_RXTO;
      ST_RXTO:  if (sts.scan_done) state_nxt = ST_TXTO;
      ST_TXTO:  if (sts.scan_done) state_nxt = ST_STAT;
      ST_STAT:  if (sts.slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_scan_only_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan != ccms_pkg::SCAN_NONE) |-> !in_tready && !cmd.update && !cmd.status)
    else $error("scan active outside a timer pass");

endmodule

[hw/rtl/ccms_dp.sv]
// ----------------------------------------------------------------------------
// ccms_dp
// Datapath: entry tables, timeout masks, scan counter, elapsed-time compare
// and the output register.
// ----------------------------------------------------------------------------
module ccms_dp #(
  parameter int TX_ENTRIES = 16,
  parameter int RX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ccms_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [1:0]                          in_tuser,
  input  ccms_pkg::ccms_cmd_t                 cmd,
  output ccms_pkg::ccms_sts_t                 sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ccms_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  // entries above the 4-bit index range can never be loaded: no storage
  localparam int TXN = (TX_ENTRIES > ccms_pkg::MAX_ENTRIES) ? ccms_pkg::MAX_ENTRIES
                                                           : TX_ENTRIES;
  localparam int RXN = (RX_ENTRIES > ccms_pkg::MAX_ENTRIES) ? ccms_pkg::MAX_ENTRIES
                                                           : RX_ENTRIES;
  localparam int TXW = (TXN > 1) ? $clog2(TXN) : 1;
  localparam int RXW = (RXN > 1) ? $clog2(RXN) : 1;

  // latched item
  logic [1:0]  mode_r;
  logic [31:0] now_r;
  logic [3:0]  idx_r;
  logic        acc_r;
  logic        isrx_r;
  logic        en_r;
  logic        cyc_r;
  logic [29:0] per_r;

  // entry tables
  logic [TXN-1:0] tx_en_r, tx_cyc_r, tx_pend_r;
  logic [29:0]    tx_per_r   [TXN];
  logic [31:0]    tx_stamp_r [TXN];
  logic [RXN-1:0] rx_en_r, rx_cyc_r;
  logic [29:0]    rx_per_r   [RXN];
  logic [31:0]    rx_stamp_r [RXN];

  logic [RXN-1:0] rx_to_r, rx_to_nxt;
  logic [TXN-1:0] tx_to_r, tx_to_nxt;
  logic [3:0]     cnt_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [3:0]  out_entry_r;
  logic [15:0] out_rxm_r;
  logic [15:0] out_txm_r;
  logic        out_last_r;

  logic [TXW-1:0] tsel, tidx;
  logic [RXW-1:0] rsel, ridx;
  logic [31:0]    tx_el, rx_el;
  logic           slot_free, step, hit, fire, scan_last;
  logic           tx_ok, rx_ok;
  logic           tx_ld, tx_clr, tx_req, rx_ld, rx_seen;
  logic [1:0]     fire_kind;

  assign tsel = cnt_r[TXW-1:0];
  assign rsel = cnt_r[RXW-1:0];
  assign tidx = idx_r[TXW-1:0];
  assign ridx = idx_r[RXW-1:0];

  // elapsed time wraps modulo 2^32
  assign tx_el = now_r - tx_stamp_r[tsel];
  assign rx_el = now_r - rx_stamp_r[rsel];

  assign slot_free = !out_valid_r || out_tready;
  assign step      = (cmd.scan != ccms_pkg::SCAN_NONE) && slot_free;

  always_comb begin
    unique case (cmd.scan)
      ccms_pkg::SCAN_TXREQ: begin
        hit       = tx_en_r[tsel] && tx_cyc_r[tsel] && !tx_pend_r[tsel] &&
                    (tx_el >= {2'b00, tx_per_r[tsel]});
        fire_kind = ccms_pkg::KIND_TXREQ;
        scan_last = (cnt_r == 4'(TXN - 1));
      end
      ccms_pkg::SCAN_RXTO: begin
        // 4*period fits in 32 bits for a 30-bit period
        hit       = rx_en_r[rsel] && rx_cyc_r[rsel] &&
                    (rx_el > {rx_per_r[rsel], 2'b00});
        fire_kind = ccms_pkg::KIND_RXTO;
        scan_last = (cnt_r == 4'(RXN - 1));
      end
      ccms_pkg::SCAN_TXTO: begin
        hit       = tx_pend_r[tsel] && (tx_el > {2'b00, tx_per_r[tsel]});
        fire_kind = ccms_pkg::KIND_TXTO;
        scan_last = (cnt_r == 4'(TXN - 1));
      end
      ccms_pkg::SCAN_NONE: begin
        hit       = 1'b0;
        fire_kind = ccms_pkg::KIND_STATUS;
        scan_last = 1'b0;
      end
    endcase
  end

  assign fire   = step && hit;
  assign tx_req = fire && (cmd.scan == ccms_pkg::SCAN_TXREQ);

  // only the first due request per pass
  assign sts.slot_free = slot_free;
  assign sts.scan_done = step && (scan_last || tx_req);

  assign tx_ok = ({1'b0, idx_r} < 5'(TXN));
  assign rx_ok = ({1'b0, idx_r} < 5'(RXN));

  assign tx_ld   = cmd.update && (mode_r == ccms_pkg::MODE_LOAD) && !isrx_r && tx_ok;
  assign rx_ld   = cmd.update && (mode_r == ccms_pkg::MODE_LOAD) && isrx_r && rx_ok;
  assign rx_seen = cmd.update && (mode_r == ccms_pkg::MODE_RXSEEN) && rx_ok;
  assign tx_clr  = cmd.update && (mode_r == ccms_pkg::MODE_TXDONE) && tx_ok && acc_r &&
                   tx_pend_r[tidx];

  always_comb begin
    rx_to_nxt = rx_to_r;
    tx_to_nxt = tx_to_r;
    if (fire && (cmd.scan == ccms_pkg::SCAN_RXTO)) rx_to_nxt[rsel] = 1'b1;
    if (fire && (cmd.scan == ccms_pkg::SCAN_TXTO)) tx_to_nxt[tsel] = 1'b1;
    if (tx_clr) tx_to_nxt[tidx] = 1'b0;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_tuser;
      now_r  <= in_tdata[31:0];
      idx_r  <= in_tdata[35:32];
      acc_r  <= in_tdata[36];
      isrx_r <= in_tdata[37];
      en_r   <= in_tdata[38];
      cyc_r  <= in_tdata[39];
      per_r  <= in_tdata[69:40];
    end
  end

  // period and stamp tables, no reset
  always_ff @(posedge clk) begin
    if (tx_ld) begin
      tx_per_r[tidx]   <= per_r;
      tx_stamp_r[tidx] <= now_r;
    end else if (tx_req) begin
      tx_stamp_r[tsel] <= now_r;
    end
    if (rx_ld) begin
      rx_per_r[ridx]   <= per_r;
      rx_stamp_r[ridx] <= now_r;
    end else if (rx_seen) begin
      rx_stamp_r[ridx] <= now_r;
    end
  end

  // flags, masks, counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_en_r   <= '0;
      tx_cyc_r  <= '0;
      tx_pend_r <= '0;
      rx_en_r   <= '0;
      rx_cyc_r  <= '0;
      rx_to_r   <= '0;
      tx_to_r   <= '0;
      cnt_r     <= '0;
    end else begin
      rx_to_r <= rx_to_nxt;
      tx_to_r <= tx_to_nxt;
      if (tx_ld) begin
        tx_en_r[tidx]   <= en_r;
        tx_cyc_r[tidx]  <= cyc_r;
        tx_pend_r[tidx] <= 1'b0;
      end else if (tx_clr) begin
        tx_pend_r[tidx] <= 1'b0;
      end else if (tx_req) begin
        tx_pend_r[tsel] <= 1'b1;
      end
      if (rx_ld) begin
        rx_en_r[ridx]  <= en_r;
        rx_cyc_r[ridx] <= cyc_r;
      end
      if (step) begin
        cnt_r <= sts.scan_done ? 4'd0 : cnt_r + 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire || (cmd.status && slot_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind_r  <= fire_kind;
      out_entry_r <= cnt_r;
      out_rxm_r   <= 16'(rx_to_nxt);
      out_txm_r   <= 16'(tx_to_nxt);
      out_last_r  <= 1'b0;
    end else if (cmd.status && slot_free) begin
      out_kind_r  <= ccms_pkg::KIND_STATUS;
      out_entry_r <= 4'd0;
      out_rxm_r   <= 16'(rx_to_r);
      out_txm_r   <= 16'(tx_to_r);
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_txm_r, out_rxm_r, out_entry_r};

  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |->
      (out_kind_r == ccms_pkg::KIND_STATUS) && (out_entry_r == 4'd0))
    else $error("last beat is not a status beat");

  a_rx_to_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((rx_to_r & $past(rx_to_r)) == $past(rx_to_r)))
    else $error("receive timeout bit cleared");

  a_tx_to_clear_one: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones($past(tx_to_r) & ~tx_to_r) <= 1))
    else $error("more than one transmit timeout bit cleared");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_entry_r) && $stable(out_kind_r))
    else $error("output register overwritten while stalled");

endmodule

[hw/rtl/can_cyclic_message_scheduler.sv]
// A timer-pass event beat is registered from the scan compare once the input
// beat is latched; the status beat of a done/seen/load item is registered from
// the status state after the update step (take, update, status beat).
// Timer pass: request, receive-timeout and transmit-timeout scans, then status;
// one entry checked per cycle while the output register can take a beat.
// Reset (rst_n low, synchronous) clears enables, pending and timeout bits;
// periods and stamps hold their values until loaded.
// ----------------------------------------------------------------------------
// can_cyclic_message_scheduler
// Periodic transmit scheduler with receive and transmit timeout supervision.
// ----------------------------------------------------------------------------
module can_cyclic_message_scheduler #(
  parameter int TX_ENTRIES = 16,
  parameter int RX_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // now[31:0], index[35:32], accepted[36], is_receive[37], enable[38],
  // cyclic[39], period[69:40], zero fill[71:70]
  input  logic [ccms_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,   // mode[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // entry[3:0], rx_timeout_mask[19:4], tx_timeout_mask[35:20], zero fill[39:36]
  output logic [ccms_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,  // kind[1:0]
  output logic                            out_tlast
);

  ccms_pkg::ccms_cmd_t cmd;
  ccms_pkg::ccms_sts_t sts;

  ccms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccms_dp #(
    .TX_ENTRIES (TX_ENTRIES),
    .RX_ENTRIES (RX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/sv/can_cyclic_message_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// can_cyclic_message_scheduler_tb
// Self-checking bench for the cyclic message scheduler. Drives timer passes,
// transmit-done, receive-seen and load beats on the input stream. A local copy
// of the entry table predicts every event and status beat. A checker compares
// each output beat against the oldest prediction. Both sides idle at random,
// and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module can_cyclic_message_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 380;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  entry;
    logic [15:0] rx_mask;
    logic [15:0] tx_mask;
    logic        last;
  } sched_event_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // now, index, accepted, is_receive, enable, cyclic, period
  logic [ccms_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;   // mode
  logic                            out_tvalid;
  logic                            out_tready;
  // entry, rx_timeout_mask, tx_timeout_mask, zero fill
  logic [ccms_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;  // kind
  logic                            out_tlast;

  // scheduler image
  logic        tx_en    [NUM_ENTRIES];
  logic        tx_cyc   [NUM_ENTRIES];
  logic        tx_busy  [NUM_ENTRIES];
  logic [29:0] tx_per   [NUM_ENTRIES];
  logic [31:0] tx_ts    [NUM_ENTRIES];
  logic        rx_en    [NUM_ENTRIES];
  logic        rx_cyc   [NUM_ENTRIES];
  logic [29:0] rx_per   [NUM_ENTRIES];
  logic [31:0] rx_ts    [NUM_ENTRIES];
  logic [15:0] rx_to_bits;
  logic [15:0] tx_to_bits;

  sched_event_t expected_events[$];

  int    errors;
  int    cycle_count;
  bit    steady;          // no idling on either side while set
  int    hold_off_cycles; // receiver long hold, consumed by the receiver process
  logic [31:0] tick;
  int    beats_in, passes, loads, dones, seens;
  int    beats_out, n_req, n_rxto, n_txto;

  can_cyclic_message_scheduler #(
    .TX_ENTRIES(NUM_ENTRIES),
    .RX_ENTRIES(NUM_ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               expected_events.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTED)
      $display("[%0d] mismatch %s: got %0h expected %0h", cycle_count, what, got, want);
    errors++;
  endtask

  function automatic void push_event(logic [1:0] kind, logic [3:0] entry, logic last);
    expected_events.push_back('{kind, entry, rx_to_bits, tx_to_bits, last});
  endfunction

  // Applies one accepted beat to the image and queues the beats it causes.
  function automatic void schedule_step(logic [1:0] mode, logic [31:0] now, logic [3:0] idx,
                                        logic acc, logic is_rx, logic en, logic cyc,
                                        logic [29:0] per);
    logic [31:0] elapsed;
    bit          raised;
    raised = 1'b0;
    case (mode)
      ccms_pkg::MODE_PASS: begin
        // only the first due entry gets a request in one pass
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!raised && tx_en[i] && tx_cyc[i] && !tx_busy[i]) begin
            elapsed = now - tx_ts[i];
            if (elapsed >= {2'b00, tx_per[i]}) begin
              tx_busy[i] = 1'b1;
              tx_ts[i] = now;
              push_event(ccms_pkg::KIND_TXREQ, 4'(i), 1'b0);
              raised = 1'b1;
            end
          end
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (rx_en[i] && rx_cyc[i]) begin
            elapsed = now - rx_ts[i];
            // four periods fit in 32 bits
            if (elapsed > {rx_per[i], 2'b00}) begin
              rx_to_bits[i] = 1'b1;
              push_event(ccms_pkg::KIND_RXTO, 4'(i), 1'b0);
            end
          end
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (tx_busy[i]) begin
            elapsed = now - tx_ts[i];
            if (elapsed > {2'b00, tx_per[i]}) begin
              tx_to_bits[i] = 1'b1;
              push_event(ccms_pkg::KIND_TXTO, 4'(i), 1'b0);
            end
          end
        end
      end
      ccms_pkg::MODE_TXDONE: begin
        if (acc && tx_busy[idx]) begin
          tx_busy[idx] = 1'b0;
          tx_to_bits[idx] = 1'b0;
        end
      end
      ccms_pkg::MODE_RXSEEN: rx_ts[idx] = now;
      default: begin
        if (is_rx) begin
          rx_en[idx] = en;
          rx_cyc[idx] = cyc;
          rx_per[idx] = per;
          rx_ts[idx] = now;
        end else begin
          tx_en[idx] = en;
          tx_cyc[idx] = cyc;
          tx_per[idx] = per;
          tx_ts[idx] = now;
          tx_busy[idx] = 1'b0;
        end
      end
    endcase
    push_event(ccms_pkg::KIND_STATUS, 4'd0, 1'b1);
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(input logic [1:0] mode, input logic [31:0] now,
                           input logic [3:0] idx, input logic acc, input logic is_rx,
                           input logic en, input logic cyc, input logic [29:0] per);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, per, cyc, en, is_rx, acc, idx, now};
    do @(posedge clk); while (!in_tready);
    schedule_step(mode, now, idx, acc, is_rx, en, cyc, per);
    beats_in++;
    case (mode)
      ccms_pkg::MODE_PASS:   passes++;
      ccms_pkg::MODE_TXDONE: dones++;
      ccms_pkg::MODE_RXSEEN: seens++;
      default:               loads++;
    endcase
  endtask

  // Unused fields of each beat carry noise the block must ignore.
  task automatic timer_pass(input logic [31:0] now);
    send_item(ccms_pkg::MODE_PASS, now, 4'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), 1'($urandom), 30'($urandom));
  endtask

  task automatic tx_done(input logic [3:0] idx, input logic acc);
    send_item(ccms_pkg::MODE_TXDONE, $urandom, idx, acc, 1'($urandom), 1'($urandom),
              1'($urandom), 30'($urandom));
  endtask

  task automatic rx_seen(input logic [3:0] idx, input logic [31:0] now);
    send_item(ccms_pkg::MODE_RXSEEN, now, idx, 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), 30'($urandom));
  endtask

  task automatic load_entry(input logic is_rx, input logic [3:0] idx, input logic en,
                            input logic cyc, input logic [29:0] per, input logic [31:0] now);
    send_item(ccms_pkg::MODE_LOAD, now, idx, 1'($urandom), is_rx, en, cyc, per);
  endtask

  // receiver: random stall per beat, plus a long hold when one is requested
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    sched_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      case (out_tuser)
        ccms_pkg::KIND_TXREQ: n_req++;
        ccms_pkg::KIND_RXTO:  n_rxto++;
        ccms_pkg::KIND_TXTO:  n_txto++;
        default: ;
      endcase
      if (expected_events.size() == 0) begin
        report_mismatch("unexpected beat, kind", 32'(out_tuser),
                        32'(ccms_pkg::KIND_STATUS));
      end else begin
        want = expected_events.pop_front();
        if (out_tuser != want.kind)
          report_mismatch("kind", 32'(out_tuser), 32'(want.kind));
        if (out_tdata[3:0] != want.entry)
          report_mismatch("entry", 32'(out_tdata[3:0]), 32'(want.entry));
        if (out_tdata[19:4] != want.rx_mask)
          report_mismatch("rx_timeout_mask", 32'(out_tdata[19:4]), 32'(want.rx_mask));
        if (out_tdata[35:20] != want.tx_mask)
          report_mismatch("tx_timeout_mask", 32'(out_tdata[35:20]), 32'(want.tx_mask));
        if (out_tlast != want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
        if (out_tdata[39:36] != 4'd0)
          report_mismatch("tdata fill", 32'(out_tdata[39:36]), 32'd0);
      end
    end
  end

  task automatic test_idle_status();
    // empty table: every beat yields status only
    timer_pass(32'd0);
    tx_done(4'd0, 1'b1);
    rx_seen(4'd0, 32'd5);
  endtask

  task automatic test_tx_schedule();
    load_entry(1'b0, 4'd1, 1'b0, 1'b1, 30'd0, 32'd90);   // disabled
    load_entry(1'b0, 4'd2, 1'b1, 1'b0, 30'd0, 32'd90);   // event-only
    load_entry(1'b0, 4'd0, 1'b1, 1'b1, 30'd10, 32'd100);
    timer_pass(32'd105);                                  // not due yet
    timer_pass(32'd110);                                  // due exactly
    timer_pass(32'd121);                                  // pending past one period
    tx_done(4'd0, 1'b0);                                  // rejected frame
    tx_done(4'd0, 1'b1);
    timer_pass(32'd125);
    tx_done(4'd0, 1'b1);
  endtask

  task automatic test_rx_timeout();
    load_entry(1'b1, 4'd3, 1'b1, 1'b1, 30'd5, 32'd200);
    timer_pass(32'd220);                                  // exactly four periods
    timer_pass(32'd221);
    rx_seen(4'd3, 32'd230);                               // bit stays set
    timer_pass(32'd231);
  endtask

  task automatic test_wrap_and_extremes();
    load_entry(1'b0, 4'd15, 1'b1, 1'b1, 30'h20, 32'hFFFF_FFF0);
    load_entry(1'b1, 4'd15, 1'b1, 1'b1, 30'h3FFF_FFFF, 32'd0);
    timer_pass(32'h10);                                   // lower entry wins
    tx_done(4'd0, 1'b1);
    timer_pass(32'h11);                                   // wrapped elapsed time
    timer_pass(32'hFFFF_FFFD);                            // just past 4 * max period
  endtask

  task automatic random_item();
    int          r;
    logic [3:0]  idx;
    logic [29:0] per;
    r = $urandom_range(0, 99);
    tick = ($urandom_range(0, 49) == 0) ? $urandom : tick + $urandom_range(0, 20);
    idx = 4'($urandom);
    if (r < 40) begin
      timer_pass(tick);
    end else if (r < 62) begin
      r = $urandom_range(0, 9);
      per = (r < 7) ? 30'($urandom_range(0, 60)) :
            (r < 9) ? 30'($urandom_range(0, 1000)) : 30'($urandom);
      load_entry(1'($urandom), idx, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                 per, tick);
    end else if (r < 85) begin
      // mostly aim at an entry that is waiting for its frame
      if ($urandom_range(0, 9) < 7) begin
        for (int k = 0; k < NUM_ENTRIES; k++) begin
          if (tx_busy[4'(idx + k)]) begin
            idx = 4'(idx + k);
            break;
          end
        end
      end
      tx_done(idx, $urandom_range(0, 3) != 0);
    end else begin
      rx_seen(idx, tick);
    end
  endtask

  task automatic test_random();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      random_item();
    end
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    tick = tick + 32'd1000;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      load_entry(1'b0, 4'(i), 1'b1, 1'b1, 30'd1, tick);
      load_entry(1'b1, 4'(i), 1'b1, 1'b1, 30'd1, tick);
    end
    // full table of events per pass while the output is held
    hold_off_cycles = 400;
    for (int k = 0; k < 18; k++) begin
      tick = tick + 32'd6;
      timer_pass(tick);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= ccms_pkg::MODE_PASS;
    errors = 0;
    cycle_count = 0;
    steady = 1'b0;
    hold_off_cycles = 0;
    tick = $urandom;
    beats_in = 0; passes = 0; loads = 0; dones = 0; seens = 0;
    beats_out = 0; n_req = 0; n_rxto = 0; n_txto = 0;
    rx_to_bits = '0;
    tx_to_bits = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tx_en[i] = 1'b0; tx_cyc[i] = 1'b0; tx_busy[i] = 1'b0;
      tx_per[i] = '0;  tx_ts[i] = '0;
      rx_en[i] = 1'b0; rx_cyc[i] = 1'b0;
      rx_per[i] = '0;  rx_ts[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_status();
    test_tx_schedule();
    test_rx_timeout();
    test_wrap_and_extremes();
    test_random();
    test_backpressure();

    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats: %0d passes, %0d loads, %0d done, %0d seen",
             beats_in, passes, loads, dones, seens);
    $display("checked %0d output beats: %0d requests, %0d rx timeouts, %0d tx timeouts",
             beats_out, n_req, n_rxto, n_txto);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[can_cyclic_message_scheduler.f]
hw/rtl/ccms_pkg.sv
hw/rtl/ccms_ctrl.sv
hw/rtl/ccms_dp.sv
hw/rtl/can_cyclic_message_scheduler.sv
tb/sv/can_cyclic_message_scheduler_tb.sv
